>>> rtl/ilp_pkg.sv
// Package for the integer literal parser: entry and handoff structs, status and
// target codes, range limits. No dependencies.
`default_nettype none
package ilp_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_ODD_HEX  = 3'd4;
  localparam logic [2:0] ST_NEG_UNS  = 3'd5;

  localparam logic [2:0] KIND_I8  = 3'd0;
  localparam logic [2:0] KIND_U8  = 3'd1;
  localparam logic [2:0] KIND_I32 = 3'd2;
  localparam logic [2:0] KIND_U32 = 3'd3;
  localparam logic [2:0] KIND_I64 = 3'd4;

  localparam logic [63:0] UMAX8   = 64'h0000_0000_0000_00ff;
  localparam logic [63:0] HALF8   = 64'h0000_0000_0000_0080;
  localparam logic [63:0] SMAX8   = 64'h0000_0000_0000_007f;
  localparam logic [63:0] UMAX32  = 64'h0000_0000_ffff_ffff;
  localparam logic [63:0] HALF32  = 64'h0000_0000_8000_0000;
  localparam logic [63:0] SMAX32  = 64'h0000_0000_7fff_ffff;
  localparam logic [63:0] UMAX64  = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] HALF64  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SMAX64  = 64'h7fff_ffff_ffff_ffff;

  localparam logic [5:0] SIG_SAT   = 6'd63;
  localparam logic [5:0] SIG_LIMIT = 6'd16;

  // classified character, as queued between front and back
  typedef struct packed {
    logic       is_last;
    logic       hex;
    logic [2:0] kind;
    logic       is_minus;
    logic       dec_ok;
    logic       hex_ok;
    logic [3:0] digit;
  } char_info_t;

  // literal state after its last character
  typedef struct packed {
    logic [63:0] accum;
    logic        beyond;
    logic        neg;
    logic        parity;
    logic [2:0]  err;
    logic        hex;
    logic [2:0]  kind;
  } snap_t;

endpackage
`default_nettype wire

>>> rtl/ilp_front.sv
// Front end: classifies each character and holds it in a two-entry queue.
// Depends on ilp_pkg.
`default_nettype none
module ilp_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  char_valid,
  output logic                       char_stall,
  input  wire logic [7:0]            char_code,
  input  wire logic                  is_last,
  input  wire logic                  syntax_hex,
  input  wire logic [2:0]            target_kind,
  output logic                       ent_valid,
  output ilp_pkg::char_info_t        ent,
  input  wire logic                  ent_take
);

  ilp_pkg::char_info_t info;
  ilp_pkg::char_info_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    info.is_last  = is_last;
    info.hex      = syntax_hex;
    info.kind     = target_kind;
    info.is_minus = (char_code == 8'h2d);
    info.dec_ok   = (char_code >= 8'h30) && (char_code <= 8'h39);
    info.hex_ok   = 1'b1;
    info.digit    = 4'd0;
    if (info.dec_ok) begin
      info.digit = char_code[3:0];
    end else if ((char_code >= 8'h61) && (char_code <= 8'h66)) begin
      info.digit = 4'(char_code - 8'h57);
    end else if ((char_code >= 8'h41) && (char_code <= 8'h46)) begin
      info.digit = 4'(char_code - 8'h37);
    end else begin
      info.hex_ok = 1'b0;
    end
  end

  assign char_stall = (count == 2'd2);
  assign push       = char_valid && !char_stall;
  assign ent_valid  = (count != 2'd0);
  assign ent        = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (ent_take) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(ent_take);
    end
  end

endmodule
`default_nettype wire

>>> rtl/ilp_back.sv
// Back end: applies queued characters to the literal state, one per cycle if
// unstalled; hands the final state to the range check. Depends on ilp_pkg.
`default_nettype none
module ilp_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  ent_valid,
  input  wire ilp_pkg::char_info_t   ent,
  output logic                       ent_take,
  output logic                       snap_valid,
  output ilp_pkg::snap_t             snap,
  input  wire logic                  snap_take
);

  logic [63:0] accum, accum_next;
  logic        beyond, beyond_next;
  logic        neg, neg_next;
  logic [1:0]  pos, pos_next;
  logic [5:0]  sig, sig_next;
  logic        parity, parity_next;
  logic [2:0]  err, err_next;
  logic [67:0] prod;
  logic        snap_free;

  assign snap_free = !snap_valid || snap_take;
  assign ent_take  = ent_valid && (!ent.is_last || snap_free);

  assign prod = ({4'd0, accum} << 3) + ({4'd0, accum} << 1) + {64'd0, ent.digit};

  always_comb begin
    accum_next  = accum;
    beyond_next = beyond;
    neg_next    = neg;
    sig_next    = sig;
    parity_next = parity;
    err_next    = err;
    pos_next    = (pos < 2'd2) ? pos + 2'd1 : pos;
    if (err == ilp_pkg::ST_OK) begin
      if (ent.hex) begin
        if (pos == 2'd2) begin
          if (!ent.hex_ok) begin
            err_next = ilp_pkg::ST_INVALID;
          end else begin
            parity_next = !parity;
            if (((accum != 64'd0) || (ent.digit != 4'd0)) && (sig < ilp_pkg::SIG_SAT)) begin
              sig_next = sig + 6'd1;
            end
            beyond_next = beyond || (sig_next > ilp_pkg::SIG_LIMIT);
            if (!beyond_next) accum_next = {accum[59:0], ent.digit};
          end
        end
      end else if ((pos == 2'd0) && ent.is_minus) begin
        neg_next = 1'b1;
      end else if (!ent.dec_ok) begin
        err_next = ilp_pkg::ST_INVALID;
      end else if (!beyond) begin
        if (prod[67:64] != 4'd0) beyond_next = 1'b1;
        else accum_next = prod[63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum  <= '0;
      beyond <= 1'b0;
      neg    <= 1'b0;
      pos    <= 2'd0;
      sig    <= 6'd0;
      parity <= 1'b0;
      err    <= ilp_pkg::ST_OK;
    end else if (ent_take) begin
      if (ent.is_last) begin
        accum  <= '0;
        beyond <= 1'b0;
        neg    <= 1'b0;
        pos    <= 2'd0;
        sig    <= 6'd0;
        parity <= 1'b0;
        err    <= ilp_pkg::ST_OK;
      end else begin
        accum  <= accum_next;
        beyond <= beyond_next;
        neg    <= neg_next;
        pos    <= pos_next;
        sig    <= sig_next;
        parity <= parity_next;
        err    <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ent_take && ent.is_last) begin
      snap.accum  <= accum_next;
      snap.beyond <= beyond_next;
      snap.neg    <= neg_next;
      snap.parity <= parity_next;
      snap.err    <= err_next;
      snap.hex    <= ent.hex;
      snap.kind   <= ent.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (ent_take && ent.is_last) begin
      snap_valid <= 1'b1;
    end else if (snap_take) begin
      snap_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ilp_finish.sv
// Range check of a finished literal against its target type, and the result
// output register. Depends on ilp_pkg.
`default_nettype none
module ilp_finish (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            snap_valid,
  input  wire ilp_pkg::snap_t  snap,
  output logic                 snap_take,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output logic [63:0]          value_bits,
  output logic [2:0]           status
);

  logic [63:0] umax, half, smax, ext, value_calc;
  logic [2:0]  status_calc;
  logic        is_signed;

  assign snap_take = snap_valid && (!result_valid || !result_stall);

  always_comb begin
    is_signed = 1'b0;
    case (snap.kind) inside
      ilp_pkg::KIND_I8, ilp_pkg::KIND_U8: begin
        umax = ilp_pkg::UMAX8;
        half = ilp_pkg::HALF8;
        smax = ilp_pkg::SMAX8;
        ext  = {{56{snap.accum[7]}}, snap.accum[7:0]};
      end
      ilp_pkg::KIND_I32, ilp_pkg::KIND_U32: begin
        umax = ilp_pkg::UMAX32;
        half = ilp_pkg::HALF32;
        smax = ilp_pkg::SMAX32;
        ext  = {{32{snap.accum[31]}}, snap.accum[31:0]};
      end
      default: begin
        umax = ilp_pkg::UMAX64;
        half = ilp_pkg::HALF64;
        smax = ilp_pkg::SMAX64;
        ext  = snap.accum;
      end
    endcase
    case (snap.kind) inside
      ilp_pkg::KIND_I8, ilp_pkg::KIND_I32, ilp_pkg::KIND_I64: is_signed = 1'b1;
      default: is_signed = 1'b0;
    endcase

    value_calc  = '0;
    status_calc = ilp_pkg::ST_OK;
    if (snap.err != ilp_pkg::ST_OK) begin
      status_calc = snap.err;
    end else if (snap.hex && snap.parity) begin
      status_calc = ilp_pkg::ST_ODD_HEX;
    end else if (!is_signed) begin
      if (snap.neg) status_calc = ilp_pkg::ST_NEG_UNS;
      else if (snap.beyond || (snap.accum > umax)) status_calc = ilp_pkg::ST_OVERFLOW;
      else value_calc = snap.accum;
    end else if (snap.neg) begin
      if (snap.beyond || (snap.accum > half)) status_calc = ilp_pkg::ST_UNDERFLOW;
      else value_calc = 64'd0 - snap.accum;
    end else if (snap.beyond || (!snap.hex && (snap.accum > smax))) begin
      status_calc = ilp_pkg::ST_OVERFLOW;
    end else begin
      value_calc = ext;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      value_bits <= value_calc;
      status     <= status_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (snap_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/integer_literal_parser_core.sv
// Integer literal parser, top level: front end and queue, back end, range check.
// Depends on ilp_pkg, ilp_front, ilp_back, ilp_finish.
// Throughput: one character per cycle when nothing stalls, set by the
// combinational multiply-by-ten and add in the back end. A last character's
// result passes the queue, the back-end handoff and the output register.
// Reset clears the queue, the literal state and the output valid.
`default_nettype none
module integer_literal_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        char_valid,
  output logic             char_stall,
  input  wire logic [7:0]  char_code,
  input  wire logic        is_last,
  input  wire logic        syntax_hex,
  input  wire logic [2:0]  target_kind,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [63:0]      value_bits,
  output logic [2:0]       status
);

  logic                ent_valid;
  ilp_pkg::char_info_t ent;
  logic                ent_take;
  logic                snap_valid;
  ilp_pkg::snap_t      snap;
  logic                snap_take;

  ilp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_code   (char_code),
    .is_last     (is_last),
    .syntax_hex  (syntax_hex),
    .target_kind (target_kind),
    .ent_valid   (ent_valid),
    .ent         (ent),
    .ent_take    (ent_take)
  );

  ilp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .ent_valid  (ent_valid),
    .ent        (ent),
    .ent_take   (ent_take),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_take  (snap_take)
  );

  ilp_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .snap_valid   (snap_valid),
    .snap         (snap),
    .snap_take    (snap_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value_bits   (value_bits),
    .status       (status)
  );

endmodule
`default_nettype wire

>>> rtl/ilp_checker.sv
// Port-level checks for integer_literal_parser_core, bound to the top level.
// Depends on ilp_pkg.
`default_nettype none
module ilp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        char_stall,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [63:0] value_bits,
  input wire logic [2:0]  status
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(value_bits) && $stable(status))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ilp_pkg::ST_OK) |-> (value_bits == 64'd0))
    else $error("non-zero value with error status");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !result_valid && !char_stall)
    else $error("outputs not cleared by reset");

endmodule

bind integer_literal_parser_core ilp_checker u_ilp_checker (
  .clk          (clk),
  .rst          (rst),
  .char_stall   (char_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .value_bits   (value_bits),
  .status       (status)
);
`default_nettype wire

>>> verif/tb_integer_literal_parser_core.sv
// Self-checking testbench for integer_literal_parser_core: directed and random literals,
// checked against an in-bench predictor. Depends on ilp_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb_integer_literal_parser_core;

  localparam logic [2:0] KIND_U64    = 3'd5;
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;
  localparam logic [63:0] LIMIT_VALS [9] = '{
    ilp_pkg::SMAX8, ilp_pkg::HALF8, ilp_pkg::UMAX8, ilp_pkg::SMAX32, ilp_pkg::HALF32,
    ilp_pkg::UMAX32, ilp_pkg::SMAX64, ilp_pkg::HALF64, ilp_pkg::UMAX64};

  class literal_scoreboard;
    typedef struct packed {
      logic [63:0] value;
      logic [2:0]  st;
    } literal_result_t;

    literal_result_t parsed_q[$];
    int errors;
    bit [63:0] accum;
    bit        beyond;
    bit        neg;
    bit [1:0]  position;
    bit [5:0]  sig_digits;
    bit        parity;
    bit [2:0]  err;

    function int pending();
      return parsed_q.size();
    endfunction

    function void note_char(bit [7:0] c, bit last, bit hex, bit [2:0] kind);
      bit [1:0] pos;
      int d;
      bit [63:0] dd, umax, half, v;
      int unsigned w;
      bit sgn;
      bit [2:0] st;
      literal_result_t r;
      pos = position;
      if (position < 2) position++;
      if (err == ilp_pkg::ST_OK) begin
        if (hex) begin
          if (pos >= 2) begin
            if (c >= "0" && c <= "9") d = c - "0";
            else if (c >= "a" && c <= "f") d = c - "a" + 10;
            else if (c >= "A" && c <= "F") d = c - "A" + 10;
            else d = -1;
            if (d < 0) begin
              err = ilp_pkg::ST_INVALID;
            end else begin
              parity = !parity;
              if ((accum != 0 || d != 0) && sig_digits < ilp_pkg::SIG_SAT) sig_digits++;
              if (sig_digits > ilp_pkg::SIG_LIMIT) beyond = 1'b1;
              if (!beyond) accum = (accum << 4) | 64'(d);
            end
          end
        end else if (pos == 0 && c == "-") begin
          neg = 1'b1;
        end else if (c < "0" || c > "9") begin
          err = ilp_pkg::ST_INVALID;
        end else if (!beyond) begin
          dd = 64'(c - "0");
          if (accum > (ilp_pkg::UMAX64 - dd) / 10) beyond = 1'b1;
          else accum = accum * 10 + dd;
        end
      end
      if (!last) return;
      v = '0;
      if (err != ilp_pkg::ST_OK) begin
        st = err;
      end else if (hex && parity) begin
        st = ilp_pkg::ST_ODD_HEX;
      end else begin
        w = (kind <= ilp_pkg::KIND_U8) ? 8 : (kind <= ilp_pkg::KIND_U32) ? 32 : 64;
        sgn = (kind <= KIND_U64) && !kind[0];
        umax = (w == 8) ? ilp_pkg::UMAX8 : (w == 32) ? ilp_pkg::UMAX32 : ilp_pkg::UMAX64;
        half = (w == 8) ? ilp_pkg::HALF8 : (w == 32) ? ilp_pkg::HALF32 : ilp_pkg::HALF64;
        if (!sgn) begin
          if (neg) st = ilp_pkg::ST_NEG_UNS;
          else if (beyond || accum > umax) st = ilp_pkg::ST_OVERFLOW;
          else begin
            v = accum;
            st = ilp_pkg::ST_OK;
          end
        end else if (neg) begin
          if (beyond || accum > half) st = ilp_pkg::ST_UNDERFLOW;
          else begin
            v = 64'd0 - accum;
            st = ilp_pkg::ST_OK;
          end
        end else if (beyond || (!hex && accum > half - 1)) begin
          st = ilp_pkg::ST_OVERFLOW;
        end else begin
          // hex into signed: low w bits reinterpreted as two's complement
          case (w)
            8:       v = {{56{accum[7]}}, accum[7:0]};
            32:      v = {{32{accum[31]}}, accum[31:0]};
            default: v = accum;
          endcase
          st = ilp_pkg::ST_OK;
        end
      end
      r.value = v;
      r.st = st;
      parsed_q.push_back(r);
      accum = '0;
      beyond = 1'b0;
      neg = 1'b0;
      position = '0;
      sig_digits = '0;
      parity = 1'b0;
      err = ilp_pkg::ST_OK;
    endfunction

    function void check_result(bit [63:0] value, bit [2:0] st);
      literal_result_t r;
      if (parsed_q.size() == 0) begin
        $error("unexpected result: value_bits %h status %0d", value, st);
        errors++;
        return;
      end
      r = parsed_q.pop_front();
      if (value !== r.value) begin
        $error("value_bits: expected %h, actual %h", r.value, value);
        errors++;
      end
      if (st !== r.st) begin
        $error("status: expected %0d, actual %0d", r.st, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        char_valid;
  logic        char_stall;
  logic [7:0]  char_code;
  logic        is_last;
  logic        syntax_hex;
  logic [2:0]  target_kind;
  logic        result_valid;
  logic        result_stall;
  logic [63:0] value_bits;
  logic [2:0]  status;

  literal_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int chars_sent = 0;
  bit hold_req = 1'b0;

  integer_literal_parser_core dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .is_last      (is_last),
    .syntax_hex   (syntax_hex),
    .target_kind  (target_kind),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value_bits   (value_bits),
    .status       (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && char_valid && !char_stall)
      sb.note_char(char_code, is_last, syntax_hex, target_kind);
    if (!rst && result_valid && !result_stall) sb.check_result(value_bits, status);
  end

  // receiver; a hold request blocks every result transfer for a long stretch
  initial begin
    int hold_left;
    hold_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic send_char(input bit [7:0] c, input bit last, input bit hx, input bit [2:0] k);
    while ($urandom_range(99) < tx_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code <= c;
    is_last <= last;
    syntax_hex <= hx;
    target_kind <= k;
    @(posedge clk);
    while (char_stall) @(posedge clk);
  endtask

  // target_kind only matters on the last character, so it is random elsewhere
  task automatic send_literal(input bit [7:0] txt[$], input bit hex, input bit mixed,
                              input bit [2:0] kind);
    bit last;
    foreach (txt[i]) begin
      last = (i == txt.size() - 1);
      send_char(txt[i], last, mixed ? 1'($urandom_range(1)) : hex,
                last ? kind : 3'($urandom_range(7)));
      chars_sent++;
    end
  endtask

  task automatic send_text(input string s, input bit hex, input bit [2:0] kind);
    bit [7:0] txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_literal(txt, hex, 1'b0, kind);
  endtask

  task automatic send_random_literal();
    bit [7:0] txt[$];
    bit [7:0] dig[$];
    bit [7:0] c;
    bit hex, mixed;
    bit [2:0] kind;
    bit [63:0] v;
    string s;
    string hex_digits = "0123456789abcdefABCDEF";
    string noise_chars = "0123456789-xXaFg ";
    int n, sel;
    kind = 3'($urandom_range(7));
    hex = 1'b0;
    mixed = 1'b0;
    if ($urandom_range(99) < 25) begin
      // noise: mode flips per character, arbitrary bytes
      mixed = 1'b1;
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(1)) c = 8'($urandom_range(255));
        else c = noise_chars[$urandom_range(noise_chars.len() - 1)];
        txt.push_back(c);
      end
    end else begin
      hex = 1'($urandom_range(1));
      sel = $urandom_range(9);
      v = {$urandom, $urandom} >> $urandom_range(63);
      if (sel >= 4 && sel <= 6) v = LIMIT_VALS[$urandom_range(8)] + 64'($urandom_range(2)) - 64'd1;
      if (!hex) begin
        if ($urandom_range(99) < 30) txt.push_back("-");
        if (sel == 9) repeat ($urandom_range(1, 3)) txt.push_back("0");
        if (sel == 7) begin
          // straddles 2^64
          s = $sformatf("1844674407370955161%0d", $urandom_range(9));
          if ($urandom_range(3) == 0) s = {s, "0"};
        end else if (sel == 8) begin
          s = "";
          repeat ($urandom_range(1, 24)) s = {s, $sformatf("%0d", $urandom_range(9))};
        end else begin
          s = $sformatf("%0d", v);
        end
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
      end else begin
        if ($urandom_range(9) < 7) begin
          txt.push_back("0");
          txt.push_back($urandom_range(1) ? "x" : "X");
        end else begin
          repeat (2) txt.push_back(8'($urandom_range(255)));
        end
        if (sel == 8) begin
          n = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(16, 24);
          repeat (n) dig.push_back(hex_digits[$urandom_range(15)]);
        end else if (sel != 7) begin
          s = $sformatf("%0h", v);
          for (int i = 0; i < s.len(); i++) dig.push_back(s[i]);
        end
        if (dig.size() % 2) dig.push_front("0");
        if (sel == 9) repeat ($urandom_range(1, 2)) begin
          dig.push_front("0");
          dig.push_front("0");
        end
        if ($urandom_range(99) < 15) begin
          if (dig.size() != 0) void'(dig.pop_back());
          else dig.push_back("7");
        end
        foreach (dig[i]) begin
          c = dig[i];
          if (c >= "a" && c <= "f" && $urandom_range(1)) c = c - 8'd32;
          txt.push_back(c);
        end
      end
    end
    send_literal(txt, hex, mixed, kind);
  endtask

  initial begin
    rst <= 1'b1;
    char_valid <= 1'b0;
    char_code <= '0;
    is_last <= 1'b0;
    syntax_hex <= 1'b0;
    target_kind <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("-", 1'b0, ilp_pkg::KIND_I8);
    send_text("0x", 1'b1, ilp_pkg::KIND_I32);
    send_text("-9", 1'b0, ilp_pkg::KIND_U8);
    send_text("255", 1'b0, ilp_pkg::KIND_U8);
    send_text("-129", 1'b0, ilp_pkg::KIND_I8);
    send_text("0xf", 1'b1, KIND_SPARE6);
    send_text("0xFf", 1'b1, KIND_SPARE7);
    send_text("1a", 1'b0, ilp_pkg::KIND_I64);
    send_text("0x80", 1'b1, ilp_pkg::KIND_I8);

    tx_idle_pct = 24;
    rx_idle_pct = 57;
    while (chars_sent < 470) send_random_literal();
    tx_idle_pct = 57;
    rx_idle_pct = 24;
    while (chars_sent < 900) send_random_literal();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    while (chars_sent < 1330) send_random_literal();
    char_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
